>>> rtl/erpu_pkg.sv
// Types, codes and the relocation classifier for the ELF relocation patch unit.
// No dependencies; every module of the unit imports it.
package erpu_pkg;

    localparam int unsigned ADDR_W = 64;
    localparam int unsigned WORD_W = 32;

    // Machine register codes
    localparam logic [2:0] M_X86_64  = 3'd0;
    localparam logic [2:0] M_ARM64   = 3'd1;
    localparam logic [2:0] M_ARM     = 3'd2;
    localparam logic [2:0] M_RISCV64 = 3'd3;
    localparam logic [2:0] M_S390X   = 3'd4;
    localparam logic [2:0] M_MIPS64  = 3'd5;
    localparam logic [2:0] M_LOONG64 = 3'd6;
    localparam logic [2:0] M_INVALID = 3'd7;

    // Relocation type codes, per machine
    localparam logic [11:0] R_NONE            = 12'd0;
    localparam logic [11:0] R_X86_64          = 12'd1;
    localparam logic [11:0] R_X86_PC32        = 12'd2;
    localparam logic [11:0] R_X86_PLT32       = 12'd4;
    localparam logic [11:0] R_X86_GOTPCREL    = 12'd9;
    localparam logic [11:0] R_X86_32          = 12'd10;
    localparam logic [11:0] R_X86_32S         = 12'd11;
    localparam logic [11:0] R_X86_GOTPCRELX   = 12'd41;
    localparam logic [11:0] R_A64_ABS64       = 12'd257;
    localparam logic [11:0] R_A64_ABS32       = 12'd258;
    localparam logic [11:0] R_A64_PREL32      = 12'd261;
    localparam logic [11:0] R_A64_JUMP26      = 12'd282;
    localparam logic [11:0] R_A64_CALL26      = 12'd283;
    localparam logic [11:0] R_A32_ABS32       = 12'd2;
    localparam logic [11:0] R_A32_REL32       = 12'd3;
    localparam logic [11:0] R_A32_CALL        = 12'd28;
    localparam logic [11:0] R_A32_JUMP24      = 12'd29;
    localparam logic [11:0] R_RV_32           = 12'd1;
    localparam logic [11:0] R_RV_64           = 12'd2;
    localparam logic [11:0] R_RV_32_PCREL     = 12'd57;
    localparam logic [11:0] R_S390_32         = 12'd4;
    localparam logic [11:0] R_S390_PC32       = 12'd5;
    localparam logic [11:0] R_S390_64         = 12'd22;
    localparam logic [11:0] R_MIPS64_32       = 12'd2;
    localparam logic [11:0] R_MIPS64_64       = 12'd18;
    localparam logic [11:0] R_LA_32           = 12'd1;
    localparam logic [11:0] R_LA_64           = 12'd2;
    localparam logic [11:0] R_LA_32_PCREL     = 12'd99;

    // Relocation kinds
    typedef logic [3:0] t_kind;
    localparam t_kind K_BAD     = 4'd0;
    localparam t_kind K_ABS64   = 4'd1;
    localparam t_kind K_ABS32U  = 4'd2;
    localparam t_kind K_ABS32S  = 4'd3;
    localparam t_kind K_PCREL32 = 4'd4;
    localparam t_kind K_GOTPC   = 4'd5;
    localparam t_kind K_BR26    = 4'd6;
    localparam t_kind K_BR24    = 4'd7;
    localparam t_kind K_NONE    = 4'd8;

    // Status and store width codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;

    localparam logic [3:0] WB_NONE  = 4'd0;
    localparam logic [3:0] WB_WORD  = 4'd4;
    localparam logic [3:0] WB_DWORD = 4'd8;

    // Place adjustments folded into P ahead of the subtract
    localparam logic [ADDR_W-1:0] GOTPC_ADJ = 64'd4;
    localparam logic [ADDR_W-1:0] BR24_ADJ  = 64'd8;

    // Branch merge masks
    localparam logic [WORD_W-1:0] BR26_KEEP = 32'hFC00_0000;
    localparam logic [WORD_W-1:0] BR24_KEEP = 32'hFF00_0000;

    // One transaction after the input stage
    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  sa;
        logic [ADDR_W-1:0]  sym;
        logic [ADDR_W-1:0]  padj;
        logic [WORD_W-1:0]  word;
    } t_stage;

    function automatic t_kind classify(input logic [2:0] m, input logic [11:0] t);
        t_kind k;
        k = K_BAD;
        if (t == R_NONE && m != M_INVALID) begin
            k = K_NONE;
        end else begin
            case (m)
                M_X86_64: begin
                    case (t) inside
                        R_X86_64:                        k = K_ABS64;
                        R_X86_PC32, R_X86_PLT32:         k = K_PCREL32;
                        R_X86_GOTPCREL, R_X86_GOTPCRELX: k = K_GOTPC;
                        R_X86_32:                        k = K_ABS32U;
                        R_X86_32S:                       k = K_ABS32S;
                        default:                         k = K_BAD;
                    endcase
                end
                M_ARM64: begin
                    case (t) inside
                        R_A64_ABS64:                  k = K_ABS64;
                        R_A64_ABS32:                  k = K_ABS32U;
                        R_A64_PREL32:                 k = K_PCREL32;
                        R_A64_JUMP26, R_A64_CALL26:   k = K_BR26;
                        default:                      k = K_BAD;
                    endcase
                end
                M_ARM: begin
                    case (t) inside
                        R_A32_ABS32:                  k = K_ABS32U;
                        R_A32_REL32:                  k = K_PCREL32;
                        R_A32_CALL, R_A32_JUMP24:     k = K_BR24;
                        default:                      k = K_BAD;
                    endcase
                end
                M_RISCV64: begin
                    case (t)
                        R_RV_32:       k = K_ABS32U;
                        R_RV_64:       k = K_ABS64;
                        R_RV_32_PCREL: k = K_PCREL32;
                        default:       k = K_BAD;
                    endcase
                end
                M_S390X: begin
                    case (t)
                        R_S390_32:   k = K_ABS32U;
                        R_S390_PC32: k = K_PCREL32;
                        R_S390_64:   k = K_ABS64;
                        default:     k = K_BAD;
                    endcase
                end
                M_MIPS64: begin
                    case (t)
                        R_MIPS64_32: k = K_ABS32U;
                        R_MIPS64_64: k = K_ABS64;
                        default:     k = K_BAD;
                    endcase
                end
                M_LOONG64: begin
                    case (t)
                        R_LA_32:       k = K_ABS32U;
                        R_LA_64:       k = K_ABS64;
                        R_LA_32_PCREL: k = K_PCREL32;
                        default:       k = K_BAD;
                    endcase
                end
                default: k = K_BAD;
            endcase
        end
        return k;
    endfunction

endpackage

>>> rtl/erpu_eval.sv
// Second stage of the ELF relocation patch unit: offset subtract, range and
// alignment checks, branch merge. Combinational; depends on erpu_pkg.
module erpu_eval (
    input  erpu_pkg::t_stage              i_stage,
    output logic [erpu_pkg::ADDR_W-1:0]   o_value,
    output logic [3:0]                    o_bytes,
    output logic [1:0]                    o_status
);
    import erpu_pkg::*;

    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] off;
    logic              sa_u32;
    logic              sa_s32;
    logic              off_s32;
    logic              off_s28;
    logic              off_s26;
    logic              off_al4;

    // GOT-relative forms ignore the addend
    assign base = (i_stage.kind == K_GOTPC) ? i_stage.sym : i_stage.sa;
    assign off  = base - i_stage.padj;

    // Signed range holds when every bit above the sign bit copies it
    assign sa_u32  = (i_stage.sa[63:32] == '0);
    assign sa_s32  = (i_stage.sa[63:31] == '0) || (i_stage.sa[63:31] == '1);
    assign off_s32 = (off[63:31] == '0) || (off[63:31] == '1);
    assign off_s28 = (off[63:27] == '0) || (off[63:27] == '1);
    assign off_s26 = (off[63:25] == '0) || (off[63:25] == '1);
    assign off_al4 = (off[1:0] == 2'b00);

    always_comb begin
        o_value  = '0;
        o_bytes  = WB_NONE;
        o_status = ST_OK;
        case (i_stage.kind)
            K_NONE: begin
            end
            K_ABS64: begin
                o_value = i_stage.sa;
                o_bytes = WB_DWORD;
            end
            K_ABS32U: begin
                if (sa_u32) begin
                    o_value = {32'd0, i_stage.sa[31:0]};
                    o_bytes = WB_WORD;
                end else begin
                    o_status = ST_RANGE;
                end
            end
            K_ABS32S: begin
                if (sa_s32) begin
                    o_value = {32'd0, i_stage.sa[31:0]};
                    o_bytes = WB_WORD;
                end else begin
                    o_status = ST_RANGE;
                end
            end
            K_PCREL32, K_GOTPC: begin
                if (off_s32) begin
                    o_value = {32'd0, off[31:0]};
                    o_bytes = WB_WORD;
                end else begin
                    o_status = ST_RANGE;
                end
            end
            K_BR26: begin
                if (off_s28 && off_al4) begin
                    o_value = {32'd0, (i_stage.word & BR26_KEEP) | {6'd0, off[27:2]}};
                    o_bytes = WB_WORD;
                end else begin
                    o_status = ST_RANGE;
                end
            end
            K_BR24: begin
                if (off_s26 && off_al4) begin
                    o_value = {32'd0, (i_stage.word & BR24_KEEP) | {8'd0, off[25:2]}};
                    o_bytes = WB_WORD;
                end else begin
                    o_status = ST_RANGE;
                end
            end
            default: begin
                o_status = ST_UNSUP;
            end
        endcase
    end

endmodule

>>> rtl/elf_relocation_patch_unit_top.sv
// Top level of the ELF relocation patch unit: machine register, input stage,
// result register. Depends on erpu_pkg and erpu_eval.
//
// Usage:
//   Raise start with a relocation request on the i_ ports; busy is always
//   low, so a transaction is taken at every clock edge with start high.
//   i_cfg_we with i_cfg_wdata writes the machine register (write it only
//   while no request is in flight).
//   Each request yields one result on o_patch_value, o_write_bytes and
//   o_status. o_valid rises at the clock edge after the one that took the
//   request and stays high for exactly one cycle; the receiver cannot stall
//   the unit. Throughput: one request per cycle. The input stage classifies
//   the type, forms S+A and the adjusted place; erpu_eval does the offset
//   subtract, range checks and branch merge into the result register.
//   Reset (synchronous, active low) sets the machine to x86_64 and drops
//   any request in flight; no result strobes after reset until a new start.
module elf_relocation_patch_unit_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic [11:0]        i_reloc_type,
    input  logic [63:0]        i_patch_address,
    input  logic [63:0]        i_symbol_address,
    input  logic signed [63:0] i_addend,
    input  logic [63:0]        i_place_pc,
    input  logic [31:0]        i_existing_word,
    output logic               o_valid,
    output logic [63:0]        o_patch_value,
    output logic [3:0]         o_write_bytes,
    output logic [1:0]         o_status
);
    import erpu_pkg::*;

    logic [2:0]        r_machine;
    logic              r_s1_valid;
    t_stage            r_s1;
    t_stage            n_s1;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_value;
    logic [3:0]        r_bytes;
    logic [1:0]        r_status;
    logic [ADDR_W-1:0] n_value;
    logic [3:0]        n_bytes;
    logic [1:0]        n_status;
    logic [ADDR_W-1:0] pc_eff;
    logic [ADDR_W-1:0] pc_adj;

    assign busy = 1'b0;

    // Input stage: classify, S+A and the place with its fixed bias
    always_comb begin
        n_s1.kind = classify(r_machine, i_reloc_type);
        pc_eff    = (i_place_pc != '0) ? i_place_pc : i_patch_address;
        case (n_s1.kind)
            K_GOTPC: pc_adj = GOTPC_ADJ;
            K_BR24:  pc_adj = BR24_ADJ;
            default: pc_adj = '0;
        endcase
        n_s1.sa   = i_symbol_address + unsigned'(i_addend);
        n_s1.sym  = i_symbol_address;
        n_s1.padj = pc_eff + pc_adj;
        n_s1.word = i_existing_word;
    end

    erpu_eval u_eval (
        .i_stage  (r_s1),
        .o_value  (n_value),
        .o_bytes  (n_bytes),
        .o_status (n_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_machine   <= M_X86_64;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_machine <= i_cfg_wdata;
            end
            r_s1_valid  <= start && !busy;
            r_out_valid <= r_s1_valid;
        end
    end

    // Payload registers advance every cycle; the valid bits qualify them
    always_ff @(posedge i_clk) begin
        r_s1     <= n_s1;
        r_value  <= n_value;
        r_bytes  <= n_bytes;
        r_status <= n_status;
    end

    assign o_valid       = r_out_valid;
    assign o_patch_value = r_value;
    assign o_write_bytes = r_bytes;
    assign o_status      = r_status;

endmodule
